[hw/rtl/cst_pkg.sv]
// cst_pkg: shared types, codes and the fixed character class table of the
// character stream tokenizer. No dependencies.
`default_nettype none
package cst_pkg;

    localparam int MANTISSA_BITS_DEF = 32;
    localparam int LINE_W            = 24;
    localparam int RES_MAX           = 3;

    // result kinds
    localparam logic [2:0] K_WCHAR  = 3'd0;
    localparam logic [2:0] K_WEND   = 3'd1;
    localparam logic [2:0] K_QCHAR  = 3'd2;
    localparam logic [2:0] K_QEND   = 3'd3;
    localparam logic [2:0] K_NUMBER = 3'd4;
    localparam logic [2:0] K_SINGLE = 3'd5;
    localparam logic [2:0] K_EOL    = 3'd6;
    localparam logic [2:0] K_EOF    = 3'd7;

    // character classes
    localparam logic [2:0] C_OTHER   = 3'd0;
    localparam logic [2:0] C_SPACE   = 3'd1;
    localparam logic [2:0] C_DIGIT   = 3'd2;
    localparam logic [2:0] C_WORD    = 3'd3;
    localparam logic [2:0] C_QUOTE   = 3'd4;
    localparam logic [2:0] C_COMMENT = 3'd5;

    // configuration register indexes
    localparam logic [1:0] R_EOL   = 2'd0;
    localparam logic [1:0] R_BLOCK = 2'd1;
    localparam logic [1:0] R_LINE  = 2'd2;
    localparam logic [1:0] R_LOWER = 2'd3;

    typedef enum logic [12:0] {
        M_IDLE     = 13'b0000000000001,
        M_AFTER_CR = 13'b0000000000010,
        M_WORD     = 13'b0000000000100,
        M_MINUS    = 13'b0000000001000,
        M_NUMBER   = 13'b0000000010000,
        M_QUOTE    = 13'b0000000100000,
        M_ESCAPE   = 13'b0000001000000,
        M_OCTAL    = 13'b0000010000000,
        M_SLASH    = 13'b0000100000000,
        M_LINE_CMT = 13'b0001000000000,
        M_BLOCK    = 13'b0010000000000,
        M_BLOCK_CR = 13'b0100000000000,
        M_BLOCK_NL = 13'b1000000000000
    } t_mode;

    typedef struct packed {
        logic eol;
        logic blk;
        logic lcmt;
        logic lower;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        value;
        logic [31:0]       mant;
        logic [3:0]        frac;
        logic              neg;
        logic [LINE_W-1:0] line;
    } t_res;

    typedef struct packed {
        t_mode             mode;
        logic [7:0]        open_q;
        logic [7:0]        esc_val;
        logic [1:0]        esc_cnt;
        logic              esc_low;
        logic [3:0]        frac;
        logic              dot;
        logic              minus;
        logic [LINE_W-1:0] line;
        logic              star;
    } t_st;

    // fixed class table
    function automatic logic [2:0] char_class(input logic [7:0] c);
        logic [2:0] k;
        k = C_OTHER;
        if (c <= 8'd32) k = C_SPACE;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c >= 8'hA0
                 || c == 8'h24 || c == 8'h5F) k = C_WORD;
        else if ((c >= 8'h30 && c <= 8'h39) || c == 8'h2D) k = C_DIGIT;
        else if (c == 8'h22 || c == 8'h27) k = C_QUOTE;
        else if (c == 8'h25) k = C_COMMENT;
        return k;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/char_stream_tokenizer_unit.sv]
// char_stream_tokenizer_unit: top level; config registers, scanner and result buffer.
// Depends on cst_pkg and cst_step.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata ch, tuser at_end
//  m_axis    out        m_axis_tvalid/tready      tdata value..line, tuser kind, tlast
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// A byte is scanned in the cycle it is accepted; its zero to three result words
// land in a three-entry buffer and leave one word per cycle while the receiver is ready.
// A byte with at most one result sustains one byte per clock while the receiver is ready;
// after one with more results, input stalls until the single output port drains the buffer.
// Reset (synchronous, active low) empties the buffer, clears the scanner and loads
// the default configuration. The config port is always ready.
`default_nettype none
module char_stream_tokenizer_unit #(
    parameter int MANTISSA_BITS = cst_pkg::MANTISSA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic [0:0]  s_axis_tuser,   // at_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // value, mantissa, frac_digits, negative, line, zeros
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data
);
    import cst_pkg::*;

    t_cfg       r_cfg;
    t_res       r_res [RES_MAX];
    logic [1:0] r_cnt;
    logic [1:0] r_rd;
    t_res       res [RES_MAX];
    logic [1:0] count;
    logic       in_acc;
    logic       out_acc;
    t_res       head;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // scanner
    cst_step #(.MANTISSA_BITS(MANTISSA_BITS)) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_ch     (s_axis_tdata),
        .i_at_end (s_axis_tuser[0]),
        .i_cfg    (r_cfg),
        .o_res    (res),
        .o_count  (count)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{eol: 1'b1, blk: 1'b1, lcmt: 1'b0, lower: 1'b0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                R_EOL:   r_cfg.eol   <= i_cfg_data[0];
                R_BLOCK: r_cfg.blk   <= i_cfg_data[0];
                R_LINE:  r_cfg.lcmt  <= i_cfg_data[0];
                R_LOWER: r_cfg.lower <= i_cfg_data[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 2'd0;
        end else if (in_acc) begin
            r_cnt <= count;
            r_rd  <= 2'd0;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 2'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    // result buffer words
    always_ff @(posedge i_clk) begin
        if (in_acc) r_res <= res;
    end

    // output word
    assign head         = r_res[r_rd];
    assign m_axis_tdata = {3'b0, head.line, head.neg, head.frac, head.mant, head.value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = (r_cnt == 2'd1);

endmodule
`default_nettype wire

[hw/rtl/cst_step.sv]
// cst_step: scanner state registers and the per-byte next-state and result logic.
// Depends on cst_pkg.
`default_nettype none
module cst_step #(
    parameter int MANTISSA_BITS = cst_pkg::MANTISSA_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [7:0]   i_ch,
    input  logic         i_at_end,
    input  cst_pkg::t_cfg i_cfg,
    output cst_pkg::t_res o_res [cst_pkg::RES_MAX],
    output logic [1:0]   o_count
);
    import cst_pkg::*;

    localparam int PW = MANTISSA_BITS + 4;

    t_st                     r_st, n_st;
    logic [MANTISSA_BITS-1:0] r_dig, n_dig;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic lc);
        if (lc && ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)))
            return c + 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            8'h61:   v = 8'h07;
            8'h62:   v = 8'h08;
            8'h66:   v = 8'h0C;
            8'h6E:   v = 8'h0A;
            8'h72:   v = 8'h0D;
            8'h74:   v = 8'h09;
            8'h76:   v = 8'h0B;
            default: v = c;
        endcase
        return v;
    endfunction

    // one pass over the byte in the current mode; returns 1 to handle it again
    function automatic logic handle(input t_st si, input logic [MANTISSA_BITS-1:0] di,
                                    input logic [7:0] c, input t_cfg cfg,
                                    output t_st so, output logic [MANTISSA_BITS-1:0] dout,
                                    output logic em, output t_res r);
        logic [2:0]    cls;
        logic          again;
        logic          is_dig;
        logic          is_oct;
        logic [PW-1:0] prod;
        cls    = char_class(c);
        so     = si;
        dout   = di;
        em     = 1'b0;
        r      = '0;
        again  = 1'b0;
        is_dig = (c >= 8'h30 && c <= 8'h39);
        is_oct = (c >= 8'h30 && c <= 8'h37);
        prod   = ({4'b0, di} << 3) + ({4'b0, di} << 1) + PW'(c[3:0]);
        case (si.mode)
            M_AFTER_CR: begin
                so.mode = M_IDLE;
                again   = (c != 8'h0A);
            end
            M_IDLE: begin
                if (cls == C_SPACE) begin
                    if (c == 8'h0D || c == 8'h0A) begin
                        so.line = si.line + 1'b1;
                        if (cfg.eol) begin
                            em     = 1'b1;
                            r.kind = K_EOL;
                        end
                        if (c == 8'h0D) so.mode = M_AFTER_CR;
                    end
                end else if (cls == C_DIGIT) begin
                    dout     = '0;
                    so.frac  = '0;
                    so.dot   = 1'b0;
                    so.minus = 1'b0;
                    if (c == 8'h2D) so.mode = M_MINUS;
                    else begin
                        so.mode = M_NUMBER;
                        again   = 1'b1;
                    end
                end else if (cls == C_WORD) begin
                    em      = 1'b1;
                    r.kind  = K_WCHAR;
                    r.value = fold(c, cfg.lower);
                    so.mode = M_WORD;
                end else if (cls == C_QUOTE) begin
                    so.open_q = c;
                    so.mode   = M_QUOTE;
                end else if (cls == C_COMMENT) begin
                    so.mode = M_LINE_CMT;
                end else if (c == 8'h2F && (cfg.blk || cfg.lcmt)) begin
                    so.mode = M_SLASH;
                end else begin
                    em      = 1'b1;
                    r.kind  = K_SINGLE;
                    r.value = c;
                end
            end
            M_WORD: begin
                em = 1'b1;
                if (cls == C_WORD || cls == C_DIGIT) begin
                    r.kind  = K_WCHAR;
                    r.value = fold(c, cfg.lower);
                end else begin
                    r.kind  = K_WEND;
                    so.mode = M_IDLE;
                    again   = 1'b1;
                end
            end
            M_MINUS: begin
                again = 1'b1;
                if (c == 8'h2E || is_dig) begin
                    so.minus = 1'b1;
                    so.mode  = M_NUMBER;
                end else begin
                    em      = 1'b1;
                    r.kind  = K_SINGLE;
                    r.value = 8'h2D;
                    so.mode = M_IDLE;
                end
            end
            M_NUMBER: begin
                if (c == 8'h2E && !si.dot) begin
                    so.dot = 1'b1;
                end else if (is_dig) begin
                    // saturate when the scaled value leaves the mantissa width
                    if (prod[PW-1:MANTISSA_BITS] != '0) dout = '1;
                    else dout = prod[MANTISSA_BITS-1:0];
                    if (si.dot && si.frac != 4'hF) so.frac = si.frac + 1'b1;
                end else begin
                    em       = 1'b1;
                    r.kind   = K_NUMBER;
                    r.mant   = 32'(di);
                    r.frac   = si.frac;
                    r.neg    = si.minus;
                    dout     = '0;
                    so.frac  = '0;
                    so.dot   = 1'b0;
                    so.minus = 1'b0;
                    so.mode  = M_IDLE;
                    again    = 1'b1;
                end
            end
            M_QUOTE: begin
                if (c == si.open_q) begin
                    em      = 1'b1;
                    r.kind  = K_QEND;
                    r.value = si.open_q;
                    so.mode = M_IDLE;
                end else if (c == 8'h0A || c == 8'h0D) begin
                    em      = 1'b1;
                    r.kind  = K_QEND;
                    r.value = si.open_q;
                    so.mode = M_IDLE;
                    again   = 1'b1;
                end else if (c == 8'h5C) begin
                    so.mode = M_ESCAPE;
                end else begin
                    em      = 1'b1;
                    r.kind  = K_QCHAR;
                    r.value = c;
                end
            end
            M_ESCAPE: begin
                if (is_oct) begin
                    so.esc_val = {5'b0, c[2:0]};
                    so.esc_cnt = 2'd1;
                    so.esc_low = ~c[2];
                    so.mode    = M_OCTAL;
                end else begin
                    em      = 1'b1;
                    r.kind  = K_QCHAR;
                    r.value = esc_map(c);
                    so.mode = M_QUOTE;
                end
            end
            M_OCTAL: begin
                if (is_oct && si.esc_cnt == 2'd1) begin
                    so.esc_val = {si.esc_val[4:0], c[2:0]};
                    so.esc_cnt = 2'd2;
                end else begin
                    em      = 1'b1;
                    r.kind  = K_QCHAR;
                    so.esc_val = '0;
                    so.esc_cnt = '0;
                    so.esc_low = 1'b0;
                    so.mode    = M_QUOTE;
                    if (is_oct && si.esc_cnt == 2'd2 && si.esc_low) begin
                        r.value = {si.esc_val[4:0], c[2:0]};
                    end else begin
                        r.value = si.esc_val;
                        again   = 1'b1;
                    end
                end
            end
            M_SLASH: begin
                if (c == 8'h2A && cfg.blk) begin
                    so.star = 1'b0;
                    so.mode = M_BLOCK;
                end else if (c == 8'h2F && cfg.lcmt) begin
                    so.mode = M_LINE_CMT;
                end else begin
                    em      = 1'b1;
                    r.kind  = K_SINGLE;
                    r.value = 8'h2F;
                    so.mode = M_IDLE;
                    again   = 1'b1;
                end
            end
            M_LINE_CMT: begin
                if (c == 8'h0A || c == 8'h0D) begin
                    so.mode = M_IDLE;
                    again   = 1'b1;
                end
            end
            M_BLOCK: begin
                if (c == 8'h2F && si.star) begin
                    so.mode = M_IDLE;
                end else if (c == 8'h0D) begin
                    so.line = si.line + 1'b1;
                    so.mode = M_BLOCK_CR;
                end else if (c == 8'h0A) begin
                    so.line = si.line + 1'b1;
                    so.mode = M_BLOCK_NL;
                end else begin
                    so.star = (c == 8'h2A);
                end
            end
            M_BLOCK_CR: begin
                if (c == 8'h0A) so.mode = M_BLOCK_NL;
                else begin
                    so.star = (c == 8'h2A);
                    so.mode = M_BLOCK;
                end
            end
            M_BLOCK_NL: begin
                so.star = (c == 8'h2A);
                so.mode = M_BLOCK;
            end
            default: begin
                so.mode = M_IDLE;
                again   = 1'b1;
            end
        endcase
        r.line = so.line;
        return again;
    endfunction

    // up to four passes over one byte, or the end-of-input flush
    always_comb begin
        t_st                      st;
        t_st                      st2;
        logic [MANTISSA_BITS-1:0] dig;
        logic [MANTISSA_BITS-1:0] dig2;
        logic                     go;
        logic                     em;
        t_res                     r;
        logic [1:0]               cnt;
        t_res                     res [RES_MAX];
        st  = r_st;
        dig = r_dig;
        go  = 1'b1;
        cnt = 2'd0;
        st2 = r_st;
        dig2 = r_dig;
        em  = 1'b0;
        r   = '0;
        for (int k = 0; k < RES_MAX; k++) res[k] = '0;
        if (i_at_end) begin
            r      = '0;
            r.line = r_st.line;
            case (r_st.mode)
                M_WORD: begin
                    res[0]      = r;
                    res[0].kind = K_WEND;
                    cnt         = 2'd1;
                end
                M_MINUS, M_SLASH: begin
                    res[0]       = r;
                    res[0].kind  = K_SINGLE;
                    res[0].value = (r_st.mode == M_MINUS) ? 8'h2D : 8'h2F;
                    cnt          = 2'd1;
                end
                M_NUMBER: begin
                    res[0]      = r;
                    res[0].kind = K_NUMBER;
                    res[0].mant = 32'(r_dig);
                    res[0].frac = r_st.frac;
                    res[0].neg  = r_st.minus;
                    cnt         = 2'd1;
                end
                M_QUOTE, M_ESCAPE: begin
                    res[0]       = r;
                    res[0].kind  = K_QEND;
                    res[0].value = r_st.open_q;
                    cnt          = 2'd1;
                end
                M_OCTAL: begin
                    res[0]       = r;
                    res[0].kind  = K_QCHAR;
                    res[0].value = r_st.esc_val;
                    res[1]       = r;
                    res[1].kind  = K_QEND;
                    res[1].value = r_st.open_q;
                    cnt          = 2'd2;
                end
                default: cnt = 2'd0;
            endcase
            res[cnt]      = r;
            res[cnt].kind = K_EOF;
            cnt           = cnt + 2'd1;
            st.mode    = M_IDLE;
            dig        = '0;
            st.frac    = '0;
            st.dot     = 1'b0;
            st.minus   = 1'b0;
            st.esc_val = '0;
            st.esc_cnt = '0;
            st.esc_low = 1'b0;
            st.star    = 1'b0;
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (go) begin
                    go  = handle(st, dig, i_ch, i_cfg, st2, dig2, em, r);
                    st  = st2;
                    dig = dig2;
                    if (em && cnt != 2'd3) begin
                        res[cnt] = r;
                        cnt      = cnt + 2'd1;
                    end
                end
            end
        end
        n_st    = st;
        n_dig   = dig;
        o_res   = res;
        o_count = cnt;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '{mode: M_IDLE, open_q: '0, esc_val: '0, esc_cnt: '0, esc_low: 1'b0,
                       frac: '0, dot: 1'b0, minus: 1'b0, line: '0, star: 1'b0};
            r_dig <= '0;
        end else if (i_load) begin
            r_st  <= n_st;
            r_dig <= n_dig;
        end
    end

endmodule
`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking testbench for char_stream_tokenizer_unit.
// Depends on cst_pkg and the tokenizer RTL; predicts every result word from its own scanner.
`timescale 1ns / 1ps
module tb_top;
    import cst_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [63:0] MANT_MAX = 64'hFFFF_FFFF;
    localparam logic [7:0] CH_LF = 8'h0A, CH_CR = 8'h0D, CH_MINUS = 8'h2D, CH_DOT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F, CH_STAR = 8'h2A, CH_BSL = 8'h5C;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [31:0] mant;
        logic [3:0]  frac;
        logic        neg;
        logic [23:0] line;
        logic        last;
    } t_token;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [0:0]  i_cfg_data;

    char_stream_tokenizer_unit i_dut (.*);

    // tokenizer shadow state
    t_token      token_q[$];
    logic [2:0]  class_tab[256];
    t_cfg        cfg;
    t_mode       mode;
    logic [7:0]  open_q, esc_val;
    logic [1:0]  esc_cnt;
    logic        esc_low, dot_seen, minus_seen, star_seen;
    logic [63:0] digits;
    logic [3:0]  frac_cnt;
    logic [23:0] line_cnt;

    int send_gap_pct, recv_gap_pct;
    int errors, cycles, sent;

    // clock
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);

    function automatic void shadow_reset();
        cfg = '{eol: 1'b1, blk: 1'b1, lcmt: 1'b0, lower: 1'b0};
        mode = M_IDLE;
        open_q = 0; esc_val = 0; esc_cnt = 0; esc_low = 0; star_seen = 0;
        digits = 0; frac_cnt = 0; dot_seen = 0; minus_seen = 0; line_cnt = 0;
        for (int i = 0; i < 256; i++) begin
            if (i <= 32) class_tab[i] = C_SPACE;
            else if ((i >= "a" && i <= "z") || (i >= "A" && i <= "Z") || i >= 8'hA0
                     || i == "$" || i == "_") class_tab[i] = C_WORD;
            else if ((i >= "0" && i <= "9") || i == "-") class_tab[i] = C_DIGIT;
            else if (i == "\"" || i == "'") class_tab[i] = C_QUOTE;
            else if (i == "%") class_tab[i] = C_COMMENT;
            else class_tab[i] = C_OTHER;
        end
    endfunction

    function automatic void push_token(logic [2:0] k, logic [7:0] v,
                                       logic [31:0] m = 0, logic [3:0] f = 0, logic n = 0);
        token_q.push_back('{kind: k, value: v, mant: m, frac: f, neg: n, line: line_cnt,
                            last: 1'b0});
    endfunction

    function automatic void push_number();
        push_token(K_NUMBER, 8'd0, digits[31:0], frac_cnt, minus_seen);
        digits = 0; frac_cnt = 0; dot_seen = 0; minus_seen = 0;
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        if (cfg.lower && ((c >= "A" && c <= "Z") || (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)))
            return c + 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] escape_char(logic [7:0] c);
        case (c)
            "a": return 8'h07;
            "b": return 8'h08;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            "v": return 8'h0B;
            default: return c;
        endcase
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_oct(logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    // one pass over a byte; returns 1 when the byte must be scanned again
    function automatic logic scan_byte(logic [7:0] c);
        logic [2:0]  k;
        logic [63:0] d;
        k = class_tab[c];
        case (mode)
            M_AFTER_CR: begin
                mode = M_IDLE;
                return c != CH_LF;
            end
            M_IDLE: begin
                if (k == C_SPACE) begin
                    if (c == CH_CR || c == CH_LF) begin
                        line_cnt = line_cnt + 1;
                        if (cfg.eol) push_token(K_EOL, 8'd0);
                        if (c == CH_CR) mode = M_AFTER_CR;
                    end
                end else if (k == C_DIGIT) begin
                    digits = 0; frac_cnt = 0; dot_seen = 0; minus_seen = 0;
                    if (c == CH_MINUS) mode = M_MINUS;
                    else begin
                        mode = M_NUMBER;
                        return 1;
                    end
                end else if (k == C_WORD) begin
                    push_token(K_WCHAR, fold_case(c));
                    mode = M_WORD;
                end else if (k == C_QUOTE) begin
                    open_q = c;
                    mode = M_QUOTE;
                end else if (k == C_COMMENT) begin
                    mode = M_LINE_CMT;
                end else if (c == CH_SLASH && (cfg.blk || cfg.lcmt)) begin
                    mode = M_SLASH;
                end else begin
                    push_token(K_SINGLE, c);
                end
                return 0;
            end
            M_WORD: begin
                if (k == C_WORD || k == C_DIGIT) begin
                    push_token(K_WCHAR, fold_case(c));
                    return 0;
                end
                push_token(K_WEND, 8'd0);
                mode = M_IDLE;
                return 1;
            end
            M_MINUS: begin
                if (c == CH_DOT || is_dec(c)) begin
                    minus_seen = 1;
                    mode = M_NUMBER;
                end else begin
                    push_token(K_SINGLE, CH_MINUS);
                    mode = M_IDLE;
                end
                return 1;
            end
            M_NUMBER: begin
                if (c == CH_DOT && !dot_seen) dot_seen = 1;
                else if (is_dec(c)) begin
                    d = c - "0";
                    if (digits > (MANT_MAX - d) / 10) digits = MANT_MAX;
                    else digits = digits * 10 + d;
                    if (dot_seen && frac_cnt < 15) frac_cnt = frac_cnt + 1;
                end else begin
                    push_number();
                    mode = M_IDLE;
                    return 1;
                end
                return 0;
            end
            M_QUOTE: begin
                if (c == open_q) begin
                    push_token(K_QEND, open_q);
                    mode = M_IDLE;
                end else if (c == CH_LF || c == CH_CR) begin
                    push_token(K_QEND, open_q);
                    mode = M_IDLE;
                    return 1;
                end else if (c == CH_BSL) mode = M_ESCAPE;
                else push_token(K_QCHAR, c);
                return 0;
            end
            M_ESCAPE: begin
                if (is_oct(c)) begin
                    esc_val = c - "0";
                    esc_cnt = 1;
                    esc_low = (c <= "3");
                    mode = M_OCTAL;
                end else begin
                    push_token(K_QCHAR, escape_char(c));
                    mode = M_QUOTE;
                end
                return 0;
            end
            M_OCTAL: begin
                if (is_oct(c) && esc_cnt == 1) begin
                    esc_val = (esc_val << 3) + (c - "0");
                    esc_cnt = 2;
                    return 0;
                end
                if (is_oct(c) && esc_cnt == 2 && esc_low) begin
                    esc_val = (esc_val << 3) + (c - "0");
                    push_token(K_QCHAR, esc_val);
                    esc_val = 0; esc_cnt = 0; esc_low = 0;
                    mode = M_QUOTE;
                    return 0;
                end
                push_token(K_QCHAR, esc_val);
                esc_val = 0; esc_cnt = 0; esc_low = 0;
                mode = M_QUOTE;
                return 1;
            end
            M_SLASH: begin
                if (c == CH_STAR && cfg.blk) begin
                    star_seen = 0;
                    mode = M_BLOCK;
                    return 0;
                end
                if (c == CH_SLASH && cfg.lcmt) begin
                    mode = M_LINE_CMT;
                    return 0;
                end
                push_token(K_SINGLE, CH_SLASH);
                mode = M_IDLE;
                return 1;
            end
            M_LINE_CMT: begin
                if (c == CH_LF || c == CH_CR) begin
                    mode = M_IDLE;
                    return 1;
                end
                return 0;
            end
            M_BLOCK: begin
                if (c == CH_SLASH && star_seen) mode = M_IDLE;
                else if (c == CH_CR) begin
                    line_cnt = line_cnt + 1;
                    mode = M_BLOCK_CR;
                end else if (c == CH_LF) begin
                    line_cnt = line_cnt + 1;
                    mode = M_BLOCK_NL;
                end else star_seen = (c == CH_STAR);
                return 0;
            end
            M_BLOCK_CR: begin
                if (c == CH_LF) mode = M_BLOCK_NL;
                else begin
                    star_seen = (c == CH_STAR);
                    mode = M_BLOCK;
                end
                return 0;
            end
            M_BLOCK_NL: begin
                star_seen = (c == CH_STAR);
                mode = M_BLOCK;
                return 0;
            end
            default: begin
                mode = M_IDLE;
                return 1;
            end
        endcase
    endfunction

    // expected result words for one accepted word
    function automatic void predict_tokens(logic [7:0] c, logic at_end);
        int n0;
        n0 = token_q.size();
        if (at_end) begin
            case (mode)
                M_WORD:   push_token(K_WEND, 8'd0);
                M_MINUS:  push_token(K_SINGLE, CH_MINUS);
                M_NUMBER: push_number();
                M_SLASH:  push_token(K_SINGLE, CH_SLASH);
                M_QUOTE, M_ESCAPE: push_token(K_QEND, open_q);
                M_OCTAL: begin
                    push_token(K_QCHAR, esc_val);
                    push_token(K_QEND, open_q);
                end
                default: ;
            endcase
            push_token(K_EOF, 8'd0);
            mode = M_IDLE;
            digits = 0; frac_cnt = 0; dot_seen = 0; minus_seen = 0;
            esc_val = 0; esc_cnt = 0; esc_low = 0; star_seen = 0;
        end else begin
            for (int i = 0; i < 4; i++)
                if (!scan_byte(c)) break;
        end
        if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // compare each accepted result word with the oldest expectation
    always @(negedge i_clk) begin
        t_token got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{kind: m_axis_tuser, value: m_axis_tdata[7:0], mant: m_axis_tdata[39:8],
                    frac: m_axis_tdata[43:40], neg: m_axis_tdata[44],
                    line: m_axis_tdata[68:45], last: m_axis_tlast};
            if (token_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word kind=%0d value=%h", got.kind,
                                           got.value);
            end else begin
                want = token_q.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp k%0d v%h m%0d f%0d n%0d l%0d t%0d",
                                  " got k%0d v%h m%0d f%0d n%0d l%0d t%0d"},
                                 want.kind, want.value, want.mant, want.frac, want.neg,
                                 want.line, want.last, got.kind, got.value, got.mant,
                                 got.frac, got.neg, got.line, got.last);
                end
            end
        end
    end

    // send one word on the input stream, called at a rising edge
    task automatic send_char(logic [7:0] c, logic at_end = 1'b0);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= at_end;
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        predict_tokens(c, at_end);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            R_EOL:   cfg.eol = v;
            R_BLOCK: cfg.blk = v;
            R_LINE:  cfg.lcmt = v;
            default: cfg.lower = v;
        endcase
    endtask

    task automatic set_config(logic [3:0] bits);
        drain_tokens();
        write_reg(R_EOL, bits[3]);
        write_reg(R_BLOCK, bits[2]);
        write_reg(R_LINE, bits[1]);
        write_reg(R_LOWER, bits[0]);
    endtask

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(5))
            0: return "a" + $urandom_range(25);
            1: return "A" + $urandom_range(25);
            2: return 8'hC0 + $urandom_range(31);
            3: return "0" + $urandom_range(9);
            4: return $urandom_range(1) ? "$" : "_";
            default: return $urandom_range(1) ? "-" : 8'hA0 + $urandom_range(95);
        endcase
    endfunction

    // one random, mostly well-formed fragment of text
    task automatic send_fragment();
        int    n;
        string esc_set;
        esc_set = "abfnrtvxq\\\n";
        case ($urandom_range(11))
            0, 1: begin
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++) send_char(pick_word_char());
                send_char(" ");
            end
            2, 3: begin
                if ($urandom_range(1)) send_char("-");
                n = ($urandom_range(5) == 0) ? $urandom_range(22, 10) : $urandom_range(4);
                for (int i = 0; i < n; i++) send_char("0" + $urandom_range(9));
                if ($urandom_range(1)) begin
                    send_char(".");
                    n = ($urandom_range(4) == 0) ? $urandom_range(18, 14) : $urandom_range(3);
                    for (int i = 0; i < n; i++) send_char("0" + $urandom_range(9));
                    if ($urandom_range(3) == 0) send_char(".");
                end
                send_char($urandom_range(1) ? " " : ",");
            end
            4, 5: begin
                send_char($urandom_range(1) ? "'" : "\"");
                n = $urandom_range(5);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(3))
                        0: send_char(8'h20 + $urandom_range(94));
                        1: begin
                            send_char(CH_BSL);
                            send_char(esc_set[$urandom_range(10)]);
                        end
                        2: begin
                            send_char(CH_BSL);
                            repeat ($urandom_range(3, 1)) send_char("0" + $urandom_range(7));
                        end
                        default: send_char($urandom_range(255));
                    endcase
                end
                case ($urandom_range(3))
                    0: send_char(CH_LF);
                    1: send_char(CH_CR);
                    default: send_char(mode == M_QUOTE ? open_q : "'");
                endcase
            end
            6: begin
                case ($urandom_range(2))
                    0: send_text("% note ");
                    1: send_text("// x ");
                    default: begin
                        send_text("/* a*");
                        if ($urandom_range(1)) send_text("\r\n/");
                        if ($urandom_range(1)) send_text("\n*");
                        send_text(" **/");
                    end
                endcase
                send_char($urandom_range(1) ? CH_LF : CH_CR);
            end
            7: begin
                case ($urandom_range(3))
                    0: send_text("\r\n");
                    1: send_text("\r\r");
                    2: send_char(CH_LF);
                    default: send_char(CH_CR);
                endcase
            end
            8: send_text($urandom_range(1) ? "-x" : "-.");
            9: send_text($urandom_range(1) ? "/ " : "a/b");
            10: send_char($urandom_range(255), 1'b1);
            default: send_char($urandom_range(255));
        endcase
    endtask

    task automatic test_directed();
        send_text("Ab_9 -.5 -x 1.2.3 'q\\t\\101\\48\\");
        send_text("\\'\r\n/*\n*/%c\n");
        send_char(8'h00);
        send_char(8'hFF);
        send_char("\"");
        send_char(8'hA5, 1'b1);
    endtask

    task automatic test_random(int phase);
        int target;
        case (phase)
            0: set_config(4'b0000);
            1: set_config(4'b1111);
            default: set_config(4'($urandom_range(15)));
        endcase
        send_gap_pct = (phase < 2) ? 24 : (phase < 4) ? 68 : 0;
        recv_gap_pct = (phase < 2) ? 68 : (phase < 4) ? 24 : 0;
        target = sent + 50;
        while (sent < target) send_fragment();
        if ($urandom_range(1)) send_char(8'h00, 1'b1);
    endtask

    initial begin
        cycles = 0; errors = 0; sent = 0;
        send_gap_pct = 0; recv_gap_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        shadow_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        for (int p = 0; p < 6; p++) test_random(p);
        drain_tokens();
        repeat (20) @(posedge i_clk);

        if (errors == 0 && token_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
